// ===== rtl/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared sizes, types and control structures for the recency cell row.
// ----------------------------------------------------------------------------
package lpr_pkg;

    // Number of page frames held in the cell row.
    localparam int FRAMES = 8;
    // Number of page identifier bits that are compared and stored.
    localparam int PAGE_BITS = 16;
    // Width of the frame count register.
    localparam int CNT_BITS = 4;
    // Width of the fault and reference counters.
    localparam int TOTAL_BITS = 16;

    typedef logic [PAGE_BITS-1:0]  page_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;
    typedef logic [TOTAL_BITS-1:0] total_t;

    // Control that the top level drives into each cell.
    typedef struct packed {
        logic load;    // a reference is accepted this cycle
        logic flush;   // clear the valid bit
        logic active;  // cell lies within the managed frames
        logic last;    // cell is the last managed frame
    } cell_ctl_t;

    // Status that each cell reports back to the top level.
    typedef struct packed {
        logic match;   // cell holds the referenced page
        logic evict;   // cell content falls off the end on this reference
    } cell_stat_t;

endpackage

// ===== rtl/lpr_cell.sv =====
// ----------------------------------------------------------------------------
// LRU recency cell
// One stack position: holds a page and its valid bit, compares it against the
// referenced page and takes its neighbor's entry when the stack shifts back.
// ----------------------------------------------------------------------------
module lpr_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  lpr_pkg::cell_ctl_t ctl,
    input  lpr_pkg::page_t     query_page,
    input  lpr_pkg::page_t     prev_page,
    input  logic               prev_valid,
    input  logic               stop_in,
    output lpr_pkg::page_t     page,
    output logic               valid,
    output logic               stop_out,
    output lpr_pkg::cell_stat_t stat
);
    import lpr_pkg::*;

    page_t page_reg;
    page_t page_next;
    logic  valid_reg;
    logic  valid_next;
    logic  match;
    logic  shift;

    // Compare and decide where the shift toward the back stops.
    always_comb
    begin
        match      = valid_reg && (page_reg == query_page);
        stop_out   = stop_in || (ctl.active && (!valid_reg || match));
        shift      = ctl.load && ctl.active && !stop_in;
        stat.match = ctl.active && match;
        stat.evict = ctl.active && ctl.last && !stop_in && valid_reg && !match;
    end

    // Next entry: flush clears, a shift takes the neighbor's entry.
    always_comb
    begin
        page_next  = page_reg;
        valid_next = valid_reg;
        if (ctl.flush)
        begin
            valid_next = 1'b0;
        end
        else if (shift)
        begin
            page_next  = prev_page;
            valid_next = prev_valid;
        end
    end

    // Valid bit is control state and is reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Page identifier needs no reset.
    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

    assign page  = page_reg;
    assign valid = valid_reg;

endmodule

// ===== rtl/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement unit
// Keeps a recency-ordered row of resident pages and reports hit, eviction
// and running fault and reference totals for each page reference.
// ----------------------------------------------------------------------------
// For each page reference, the row of FRAMES cells
// compares every resident page with the reference in parallel and shifts the
// entries in front of the hit, or of the first free or last managed frame,
// back by one place. The result lands in an output register, so the unit
// takes one reference per cycle while the result side keeps taking transfers;
// the compare chain through the cell row sets the cycle time. Writing the
// frame count flushes the resident set and keeps both totals.
module lru_page_replacement (
    input  logic        clk,
    input  logic        rst_n,
    // Frame count register write.
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    // Page references: tdata = page_number[15:0].
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // Results: tdata = hit[0], evicted_valid[1], evicted_page[17:2],
    // fault_total[33:18], reference_total[49:34], zero fill[55:50].
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata
);
    import lpr_pkg::*;

    cnt_t       frames_reg;
    cnt_t       frames_next;
    cnt_t       active_cnt;
    total_t     fault_reg;
    total_t     fault_next;
    total_t     ref_reg;
    total_t     ref_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [55:0] out_data_reg;
    logic [55:0] out_data_next;
    logic       accept;
    page_t      query_page;

    page_t      cell_page  [FRAMES];
    logic       cell_valid [FRAMES];
    page_t      prev_page  [FRAMES];
    logic       prev_valid [FRAMES];
    logic       stop_chain [FRAMES+1];
    cell_ctl_t  cell_ctl   [FRAMES];
    cell_stat_t cell_stat  [FRAMES];

    logic       hit;
    logic       evict_valid;
    page_t      evict_page;

    assign query_page    = s_axis_tdata[PAGE_BITS-1:0];
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // The front cell never sees a stop from ahead of it.
    assign stop_chain[0] = 1'b0;

    // Clamp the frame count to the range the row supports.
    always_comb
    begin
        if (frames_reg == '0)
        begin
            active_cnt = cnt_t'(1);
        end
        else if (frames_reg > cnt_t'(FRAMES))
        begin
            active_cnt = cnt_t'(FRAMES);
        end
        else
        begin
            active_cnt = frames_reg;
        end
    end

    // Per-cell control and the links between neighbors.
    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            cell_ctl[i].load   = accept;
            cell_ctl[i].flush  = cfg_we;
            cell_ctl[i].active = (cnt_t'(i) < active_cnt);
            cell_ctl[i].last   = (cnt_t'(i + 1) == active_cnt);
            if (i == 0)
            begin
                prev_page[i]  = query_page;
                prev_valid[i] = 1'b1;
            end
            else
            begin
                prev_page[i]  = cell_page[i-1];
                prev_valid[i] = cell_valid[i-1];
            end
        end
    end

    // Row of recency cells, front of the stack at index zero.
    for (genvar g = 0; g < FRAMES; g++)
    begin : g_cell
        lpr_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (cell_ctl[g]),
            .query_page (query_page),
            .prev_page  (prev_page[g]),
            .prev_valid (prev_valid[g]),
            .stop_in    (stop_chain[g]),
            .page       (cell_page[g]),
            .valid      (cell_valid[g]),
            .stop_out   (stop_chain[g+1]),
            .stat       (cell_stat[g])
        );
    end

    // Gather hit and eviction from the cells.
    always_comb
    begin
        hit         = 1'b0;
        evict_valid = 1'b0;
        evict_page  = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            hit         = hit | cell_stat[i].match;
            evict_valid = evict_valid | cell_stat[i].evict;
            evict_page  = evict_page | (cell_stat[i].evict ? cell_page[i] : '0);
        end
    end

    // Saturating totals and the result register.
    always_comb
    begin
        frames_next    = cfg_we ? cfg_wdata : frames_reg;
        fault_next     = fault_reg;
        ref_next       = ref_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (ref_reg != '1)
            begin
                ref_next = ref_reg + total_t'(1);
            end
            if (!hit && (fault_reg != '1))
            begin
                fault_next = fault_reg + total_t'(1);
            end
            out_valid_next = 1'b1;
            out_data_next  = {6'b0, ref_next, fault_next, 16'(evict_page),
                              evict_valid, hit};
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg    <= cnt_t'(FRAMES);
            fault_reg     <= '0;
            ref_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            frames_reg    <= frames_next;
            fault_reg     <= fault_next;
            ref_reg       <= ref_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== tb/lru_page_replacement_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Streams page references into the unit and checks every result transfer
// against a cycle-free software predictor of the recency stack and totals.
// ----------------------------------------------------------------------------
// A queue of pending page references feeds a clocked driver. A clocked
// monitor predicts each accepted reference, keeps the expected results in
// order and compares every result transfer field by field. The stimulus runs
// a short directed part, then mixed working-set phases under twelve frame
// count settings, then a short phase after a last flush.
// Both stream sides idle at random, except in a stretch with no idling, and
// the result side holds off once for a long time so that the unit stalls.
module lru_page_replacement_tb;

    import lpr_pkg::*;

    // Quiet cycles allowed before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Length of the long result-side hold-off.
    localparam int HOLD_OFF_CYCLES = 400;
    // References per mixed working-set phase.
    localparam int PHASE_ITEMS = 128;

    // Result fields, last field in the lowest bits as on m_axis_tdata.
    typedef struct packed {
        total_t reference_total;
        total_t fault_total;
        page_t  evicted_page;
        logic   evicted_valid;
        logic   hit;
    } page_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    // Pending references and expected results.
    page_t        page_queue[$];
    page_result_t expected_results[$];

    // Predictor state: recency stack, valid bits, totals and frame count.
    page_t  resident_page[FRAMES];
    logic   resident_valid[FRAMES];
    total_t fault_tally;
    total_t reference_tally;
    cnt_t   frame_setting;

    // Run control and bookkeeping.
    logic        calm = 1'b0;
    int unsigned hold_off_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned failures = 0;
    int unsigned references_accepted = 0;
    int unsigned hits_checked = 0;
    int unsigned evictions_checked = 0;
    int unsigned settings_used = 0;

    lru_page_replacement u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Append one reference to the pending queue.
    function automatic void queue_page(input page_t page);
        page_queue.insert(page_queue.size(), page);
    endfunction

    // Shift entries 0..last-1 back one place and put the page at the front.
    function automatic void move_to_front(input int last, input page_t page);
        int i;
        for (i = last; i > 0; i--)
        begin
            resident_page[i]  = resident_page[i-1];
            resident_valid[i] = resident_valid[i-1];
        end
        resident_page[0]  = page;
        resident_valid[0] = 1'b1;
    endfunction

    // Resolve one reference against the predicted stack and update it.
    function automatic page_result_t resolve_reference(input page_t page);
        page_result_t r;
        int n;
        int pos;
        int slot;
        int i;
        r = '0;
        if (frame_setting == 0)
            n = 1;
        else if (frame_setting > FRAMES)
            n = FRAMES;
        else
            n = frame_setting;
        if (reference_tally != '1)
            reference_tally++;
        // The lowest matching position wins.
        pos = n;
        for (i = n - 1; i >= 0; i--)
            if (resident_valid[i] && resident_page[i] == page)
                pos = i;
        if (pos < n)
        begin
            r.hit = 1'b1;
            move_to_front(pos, page);
        end
        else
        begin
            // First free frame, or the last managed one when all are full.
            slot = n - 1;
            for (i = n - 1; i >= 0; i--)
                if (!resident_valid[i])
                    slot = i;
            if (resident_valid[slot])
            begin
                r.evicted_valid = 1'b1;
                r.evicted_page  = resident_page[slot];
            end
            if (fault_tally != '1)
                fault_tally++;
            move_to_front(slot, page);
        end
        r.fault_total     = fault_tally;
        r.reference_total = reference_tally;
        return r;
    endfunction

    // Count a failure and report it.
    task automatic note_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
        failures++;
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
    endtask

    // Reference driver: offers the head of the queue, idling at random.
    always @(posedge clk)
    begin : reference_driver
        logic holding;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                void'(page_queue.pop_front());
            holding = s_axis_tvalid && !s_axis_tready;
            if (!holding)
            begin
                if (page_queue.size() != 0 && (calm || $urandom_range(99) >= 25))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= page_queue[0];
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: predicts accepted references and checks each result.
    always @(posedge clk)
    begin : result_monitor
        page_result_t got;
        page_result_t want;
        int i;
        if (!rst_n)
        begin
            m_axis_tready   <= 1'b0;
            fault_tally     = '0;
            reference_tally = '0;
            frame_setting   = 4'd8;
            for (i = 0; i < FRAMES; i++)
            begin
                resident_page[i]  = '0;
                resident_valid[i] = 1'b0;
            end
        end
        else
        begin
            // A frame count write flushes the resident set and keeps totals.
            if (cfg_we)
            begin
                frame_setting = cfg_wdata;
                for (i = 0; i < FRAMES; i++)
                    resident_valid[i] = 1'b0;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                references_accepted++;
                expected_results.insert(expected_results.size(),
                                        resolve_reference(s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[49:0];
                if (expected_results.size() == 0)
                begin
                    failures++;
                    $error("result transfer with no reference outstanding: 0x%0h",
                           m_axis_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    hits_checked      += want.hit;
                    evictions_checked += want.evicted_valid;
                    if (got.hit != want.hit)
                        note_mismatch("hit", want.hit, got.hit);
                    if (got.evicted_valid != want.evicted_valid)
                        note_mismatch("evicted_valid", want.evicted_valid,
                                      got.evicted_valid);
                    if (got.evicted_page != want.evicted_page)
                        note_mismatch("evicted_page", want.evicted_page,
                                      got.evicted_page);
                    if (got.fault_total != want.fault_total)
                        note_mismatch("fault_total", want.fault_total,
                                      got.fault_total);
                    if (got.reference_total != want.reference_total)
                        note_mismatch("reference_total", want.reference_total,
                                      got.reference_total);
                end
            end
            // Long hold-off first, otherwise random stalls.
            if (hold_off_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_off_left--;
            end
            else
            begin
                m_axis_tready <= calm || $urandom_range(99) >= 25;
            end
        end
    end

    // Watchdog on cycles in which neither side moves a transfer.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles.", quiet_cycles);
            $display("FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Wait until every reference is accepted and every result has arrived.
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (page_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    endtask

    // Write the frame count register while the unit is idle.
    task automatic write_frame_count(input cnt_t value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
        @(negedge clk);
    endtask

    // A page identifier, biased toward the all-zero and all-one extremes.
    function automatic page_t pick_page();
        int unsigned roll;
        roll = $urandom_range(15);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return '1;
        else
            return page_t'($urandom_range(16'hFFFF));
    endfunction

    // Mixed phase: mostly a drifting working set, some repeats and noise.
    task automatic queue_mixed_references(input int unsigned pool_size,
                                          input int unsigned count);
        page_t pool[$];
        int unsigned k;
        int unsigned roll;
        for (k = 0; k < pool_size; k++)
            pool.insert(pool.size(), pick_page());
        for (k = 0; k < count; k++)
        begin
            roll = $urandom_range(99);
            if (roll < 5)
                pool[$urandom_range(pool_size - 1)] = pick_page();
            if (roll < 80)
                queue_page(pool[$urandom_range(pool_size - 1)]);
            else if (roll < 88 && page_queue.size() != 0)
                queue_page(page_queue[$]);
            else
                queue_page(pick_page());
        end
    endtask

    // Stimulus sequence.
    initial
    begin : stimulus
        cnt_t settings[12];
        int unsigned p;
        int unsigned k;
        int unsigned managed;
        int unsigned pool_size;

        settings = '{4'd1, 4'd8, 4'd0, 4'd9, 4'd15, 4'd2, 4'd3, 4'd4,
                     4'd5, 4'd6, 4'd7, 4'd0};
        settings[11] = cnt_t'($urandom_range(15));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extreme pages, page zero as a real page, hits just behind the
        // front and at the back, fill to all eight frames, then evictions.
        queue_page(16'h0000);
        queue_page(16'hFFFF);
        queue_page(16'h0000);
        queue_page(16'hFFFF);
        for (k = 1; k <= 7; k++)
            queue_page(page_t'(k));
        queue_page(16'hFFFF);
        queue_page(16'h0000);
        wait_until_drained();

        // Frame count of zero behaves as a single frame.
        write_frame_count(4'd0);
        queue_page(16'h1234);
        queue_page(16'h1234);
        queue_page(16'h8000);
        queue_page(16'h8000);
        wait_until_drained();

        // A count above the frame total is clipped, and the flush empties it.
        write_frame_count(4'd15);
        queue_page(16'h8000);
        queue_page(16'h8000);
        queue_page(16'h0003);
        wait_until_drained();

        // Mixed phases under twelve frame count settings.
        for (p = 0; p < 12; p++)
        begin
            write_frame_count(settings[p]);
            managed = (settings[p] == 0) ? 1 : ((settings[p] > FRAMES) ? FRAMES : settings[p]);
            pool_size = managed + $urandom_range(4);
            pool_size = (pool_size > 1) ? pool_size - 1 : 1;
            if (p == 2)
                hold_off_left = HOLD_OFF_CYCLES;
            calm = (p == 6);
            queue_mixed_references(pool_size, PHASE_ITEMS);
            wait_until_drained();
        end
        calm = 1'b0;

        // Totals carry across a flush and further references.
        write_frame_count(4'd8);
        queue_mixed_references(4, 16);
        wait_until_drained();

        repeat (4) @(posedge clk);
        $display("Checked %0d page references under %0d frame count writes:",
                 references_accepted, settings_used);
        $display("%0d hits and %0d evictions, with a long result stall along the way.",
                 hits_checked, evictions_checked);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== lru_page_replacement.f =====
rtl/lpr_pkg.sv
rtl/lpr_cell.sv
rtl/lru_page_replacement.sv
tb/lru_page_replacement_tb.sv
